FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with the active-low reset as disable
`define STTT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sleep timer table check failed");

// stalled handshake keeps its payload
`define STTT_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, pay) \
  `STTT_ASSERT(lbl, clk, rstn, (vld && !rdy) |=> (vld && $stable(pay)))

`endif

FILE: hdl/sttt_pkg.sv
// shared types and constants of the sleep timer table
package sttt_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int PID_W      = 8;
  localparam int MS_W       = 32;
  localparam int CD_W       = 27;
  localparam int TICK_MS    = 55;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam int EV_W       = 2;

  // result event codes
  typedef enum logic [EV_W-1:0] {
    EV_BLOCKED = 2'd0,
    EV_WOKEN   = 2'd1,
    EV_SHORT   = 2'd2,
    EV_FULL    = 2'd3
  } ev_e;

  // what a cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_BACK = 2'd1,
    CELL_FWD  = 2'd2,
    CELL_LOAD = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic             valid;
    logic [PID_W-1:0] pid;
    logic [CD_W-1:0]  cd;
  } slot_t;

endpackage

FILE: hdl/sttt_div55.sv
// divide a 32-bit duration by the tick length, four quotient bits a cycle
module sttt_div55 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sttt_pkg::MS_W-1:0]   dividend_i,
  output logic                        busy_o,
  output logic [sttt_pkg::CD_W-1:0]   quot_o
);

  localparam int BITS  = 4;
  localparam int STEPS = sttt_pkg::MS_W / BITS;
  localparam int CNT_W = $clog2(STEPS);
  localparam int REM_W = $clog2(sttt_pkg::TICK_MS);

  logic [sttt_pkg::MS_W-1:0] num_q, num_d;
  // quotient bits above the countdown width are always zero and shift out
  logic [sttt_pkg::CD_W-1:0] quo_q, quo_d;
  logic [REM_W-1:0]          rem_q, rem_d;
  logic [CNT_W-1:0]          cnt_q;
  logic                      busy_q;
  logic [BITS-1:0]           qbits;

  // restoring steps against the constant divisor, remainder stays below it
  always_comb begin
    logic [REM_W:0]   t;
    logic [REM_W-1:0] r;
    r = rem_q;
    for (int k = 0; k < BITS; k++) begin
      t = {r, num_q[sttt_pkg::MS_W-1-k]};
      if (t >= (REM_W+1)'(sttt_pkg::TICK_MS)) begin
        t = t - (REM_W+1)'(sttt_pkg::TICK_MS);
        qbits[BITS-1-k] = 1'b1;
      end else begin
        qbits[BITS-1-k] = 1'b0;
      end
      r = t[REM_W-1:0];
    end
    rem_d = r;
    num_d = num_q << BITS;
    quo_d = {quo_q[sttt_pkg::CD_W-BITS-1:0], qbits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(STEPS - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

FILE: hdl/sttt_cell.sv
// one table slot: holds an entry and takes it from a neighbor or the load bus
module sttt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sttt_pkg::cell_op_e  op_i,
  input  sttt_pkg::slot_t     prev_i,
  input  sttt_pkg::slot_t     next_i,
  input  sttt_pkg::slot_t     load_i,
  output sttt_pkg::slot_t     slot_o
);

  sttt_pkg::slot_t              slot_d;
  logic                         valid_q;
  logic [sttt_pkg::PID_W-1:0]   pid_q;
  logic [sttt_pkg::CD_W-1:0]    cd_q;

  always_comb begin
    case (op_i)
      sttt_pkg::CELL_BACK: slot_d = prev_i;
      sttt_pkg::CELL_FWD:  slot_d = next_i;
      sttt_pkg::CELL_LOAD: slot_d = load_i;
      default:             slot_d = slot_o;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= slot_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pid_q <= slot_d.pid;
    cd_q  <= slot_d.cd;
  end

  assign slot_o = {valid_q, pid_q, cd_q};

endmodule

FILE: hdl/sleep_timer_table_top.sv
// sleep timer table: a chain of slot cells kept newest first
// sleep request: the milliseconds are divided by 55 into ticks, then the entry is inserted
// sleep request: the next item is taken only once the result is loaded, which output stalls delay
// tick: the next item is taken only after every occupied slot is visited and the held wake is out
// one head slot is visited per cycle while no expiry stalls; a held wake waits for the output register to free up
// reset (async, active low) empties the table at once; no clearing pass is needed
module sleep_timer_table_top #(
  parameter int SLOTS = sttt_pkg::SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input item
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] process_id, [39:8] milliseconds
  input  logic [sttt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] kind: 0 tick, 1 sleep request
  input  logic                              s_axis_tuser,
  // result item
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] process_id_out, [9:8] event_res, [15:10] zero
  output logic [sttt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // last result of the input item
  output logic                              m_axis_tlast
);

  localparam int OCC_W = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_REQ,
    ST_TICK,
    ST_FLUSH
  } state_e;

  state_e                           state_q;
  logic [OCC_W-1:0]                 occ_q;     // occupied slots
  logic [OCC_W-1:0]                 rem_q;     // slots still to visit on a tick
  logic                             pend_v_q;  // wake held back until we know if it is last
  logic [sttt_pkg::PID_W-1:0]       pend_pid_q;
  logic [sttt_pkg::PID_W-1:0]       req_pid_q;

  // output register
  logic                             out_v_q;
  logic [sttt_pkg::PID_W-1:0]       out_pid_q;
  sttt_pkg::ev_e                    out_ev_q;
  logic                             out_last_q;

  logic                             accept;
  logic                             out_free;
  logic                             out_load;
  logic                             div_start;
  logic                             div_busy;
  logic [sttt_pkg::CD_W-1:0]        quot;
  logic                             full;
  logic                             head_exp;
  logic                             tick_step;
  logic                             req_go;
  logic                             ins;

  sttt_pkg::slot_t                  slot_w [SLOTS];
  sttt_pkg::slot_t                  prev_w [SLOTS];
  sttt_pkg::slot_t                  next_w [SLOTS];
  sttt_pkg::cell_op_e               op_w   [SLOTS];
  sttt_pkg::slot_t                  new_entry;
  sttt_pkg::slot_t                  survivor;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign div_start     = accept && s_axis_tuser;
  assign out_free      = !out_v_q || m_axis_tready;

  // duration to ticks
  sttt_div55 u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (s_axis_tdata[sttt_pkg::IN_DATA_W-1:sttt_pkg::PID_W]),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // table is full when the tail cell holds an entry
  assign full = slot_w[SLOTS-1].valid;

  // head entry expires on this tick when its countdown is one or zero
  assign head_exp = (slot_w[0].cd <= sttt_pkg::CD_W'(1));

  // a tick step pops the head; an expiry needs room to push out the held wake
  assign tick_step = (state_q == ST_TICK) && (rem_q != '0) &&
                     (!head_exp || !pend_v_q || out_free);
  assign req_go    = (state_q == ST_REQ) && out_free;
  assign ins       = req_go && (quot != '0) && !full;

  // the output register takes a new result
  assign out_load  = req_go ||
                     (tick_step && head_exp && pend_v_q) ||
                     ((state_q == ST_FLUSH) && pend_v_q && out_free);

  always_comb begin
    new_entry.valid = 1'b1;
    new_entry.pid   = req_pid_q;
    new_entry.cd    = quot;
    survivor.valid  = 1'b1;
    survivor.pid    = slot_w[0].pid;
    survivor.cd     = slot_w[0].cd - 1'b1;
  end

  // neighbor wiring and per-cell operation
  // tick: all cells move toward the head, a surviving head re-enters
  // just behind the entries already in the chain, keeping the order
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      prev_w[i] = (i == 0) ? new_entry : slot_w[(i == 0) ? 0 : i-1];
      next_w[i] = (i == SLOTS-1) ? '0 : slot_w[(i == SLOTS-1) ? i : i+1];
      op_w[i]   = sttt_pkg::CELL_HOLD;
      if (ins) begin
        op_w[i] = sttt_pkg::CELL_BACK;
      end else if (tick_step) begin
        if (!head_exp && (occ_q == OCC_W'(i + 1))) begin
          op_w[i] = sttt_pkg::CELL_LOAD;
        end else begin
          op_w[i] = sttt_pkg::CELL_FWD;
        end
      end
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    sttt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .op_i   (op_w[g]),
      .prev_i (prev_w[g]),
      .next_i (next_w[g]),
      .load_i (survivor),
      .slot_o (slot_w[g])
    );
  end

  // sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      occ_q      <= '0;
      rem_q      <= '0;
      pend_v_q   <= 1'b0;
      pend_pid_q <= '0;
      req_pid_q  <= '0;
      out_v_q    <= 1'b0;
      out_pid_q  <= '0;
      out_ev_q   <= sttt_pkg::EV_BLOCKED;
      out_last_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            req_pid_q <= s_axis_tdata[sttt_pkg::PID_W-1:0];
            if (s_axis_tuser) begin
              state_q <= ST_DIV;
            end else begin
              rem_q    <= occ_q;
              pend_v_q <= 1'b0;
              state_q  <= ST_TICK;
            end
          end
        end
        ST_DIV: begin
          if (!div_busy) begin
            state_q <= ST_REQ;
          end
        end
        ST_REQ: begin
          if (req_go) begin
            out_pid_q  <= req_pid_q;
            out_last_q <= 1'b1;
            if (quot == '0) begin
              out_ev_q <= sttt_pkg::EV_SHORT;
            end else if (full) begin
              out_ev_q <= sttt_pkg::EV_FULL;
            end else begin
              out_ev_q <= sttt_pkg::EV_BLOCKED;
              occ_q    <= occ_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_TICK: begin
          if (rem_q == '0) begin
            state_q <= ST_FLUSH;
          end else if (tick_step) begin
            rem_q <= rem_q - 1'b1;
            if (head_exp) begin
              occ_q      <= occ_q - 1'b1;
              pend_v_q   <= 1'b1;
              pend_pid_q <= slot_w[0].pid;
              if (pend_v_q) begin
                out_pid_q  <= pend_pid_q;
                out_ev_q   <= sttt_pkg::EV_WOKEN;
                out_last_q <= 1'b0;
              end
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_v_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_pid_q  <= pend_pid_q;
            out_ev_q   <= sttt_pkg::EV_WOKEN;
            out_last_q <= 1'b1;
            pend_v_q   <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {(sttt_pkg::OUT_DATA_W - sttt_pkg::PID_W - sttt_pkg::EV_W)'(0),
                          out_ev_q, out_pid_q};
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: hdl/sttt_checker.sv
// port-level checks of the sleep timer table and their binding
`include "assert_macros.svh"

module sttt_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [sttt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tlast
);

  logic in_acc;
  logic req_acc;
  logic out_not_woken;
  logic [sttt_pkg::OUT_DATA_W:0] out_pay;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign req_acc       = in_acc && s_axis_tuser;
  assign out_not_woken = m_axis_tvalid && (m_axis_tdata[9:8] != sttt_pkg::EV_WOKEN);
  assign out_pay       = {m_axis_tlast, m_axis_tdata};

  // result stays put while stalled
  `STTT_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, out_pay)

  // every accepted item keeps the input closed for at least the next cycle
  `STTT_ASSERT(a_busy_after_acc, clk_i, rst_ni, in_acc |=> !s_axis_tready)

  // request answers are always single and final
  `STTT_ASSERT(a_req_last, clk_i, rst_ni, out_not_woken |-> m_axis_tlast)

  // a sleep request never answers within the next cycle
  `STTT_ASSERT(a_req_delay, clk_i, rst_ni, req_acc |=> !m_axis_tvalid || $past(m_axis_tvalid))

endmodule

bind sleep_timer_table_top sttt_checker u_sttt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
